### design/aik_pkg.sv
package aik_pkg;

    // Default build settings.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 8;

    // Accumulator scale of all angle work: degrees times 2^24.
    localparam int ANG_FRAC = 24;

    // Field and datapath widths.
    localparam int CFG_W   = 17;   // length registers
    localparam int XYZ_W   = 20;   // input coordinates
    localparam int R_W     = 21;   // horizontal radius root
    localparam int C_W     = 22;   // reach root
    localparam int LEN_W   = 22;   // side lengths into the cosine rule
    localparam int DIV_W   = 31;   // cosine ratio quotient and divisor
    localparam int CIN_W   = 32;   // CORDIC inputs
    localparam int CX_W    = 35;   // CORDIC vector components
    localparam int ANG_W   = 34;   // CORDIC angle accumulator
    localparam int NORM_LEN = 30;  // CORDIC vectors are scaled to at least 2^29

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_UPPER_ARM = 2'd0;
    localparam logic [1:0] REG_FOREARM   = 2'd1;
    localparam logic [1:0] REG_HEAD_OFS  = 2'd2;
    localparam logic [1:0] REG_CENTER_OFS = 2'd3;

    // Default arm geometry in whole millimeters.
    localparam int UPPER_ARM_MM = 135;
    localparam int FOREARM_MM   = 170;
    localparam int HEAD_OFS_MM  = 50;
    localparam int CENTER_OFS_MM = 47;

    // Output field widths.
    localparam int SHOULDER_W = 18;
    localparam int ELBOW_W    = 18;
    localparam int BASE_W     = 16;

    // Reset value of a length register: whole millimeters in the fixed-point format.
    function automatic logic [CFG_W-1:0] cfg_reset(input int mm, input int frac);
        logic [47:0] wide;
        begin
            wide = 48'(mm) << frac;
            return wide[CFG_W-1:0];
        end
    endfunction

    // atan(2^-i) in degrees scaled by 2^24.
    function automatic logic signed [ANG_W-1:0] atan_q24(input int i);
        begin
            case (i)
                0:  return ANG_W'(754974720);
                1:  return ANG_W'(445687602);
                2:  return ANG_W'(235489088);
                3:  return ANG_W'(119537938);
                4:  return ANG_W'(60000934);
                5:  return ANG_W'(30029717);
                6:  return ANG_W'(15018523);
                7:  return ANG_W'(7509720);
                8:  return ANG_W'(3754917);
                9:  return ANG_W'(1877466);
                10: return ANG_W'(938734);
                11: return ANG_W'(469367);
                12: return ANG_W'(234684);
                13: return ANG_W'(117342);
                14: return ANG_W'(58671);
                15: return ANG_W'(29335);
                16: return ANG_W'(14668);
                17: return ANG_W'(7334);
                18: return ANG_W'(3667);
                19: return ANG_W'(1833);
                20: return ANG_W'(917);
                21: return ANG_W'(458);
                22: return ANG_W'(229);
                23: return ANG_W'(115);
                default: return '0;
            endcase
        end
    endfunction

    // Cycles through the CORDIC unit: normalize, quadrant fold, then the rotations.
    function automatic int cordic_lat(input int stages);
        return stages + 2;
    endfunction

    // Cycles through one cosine-rule angle unit.
    function automatic int law_lat(input int stages);
        return 4 + DIV_W + 3 + DIV_W + cordic_lat(stages) + 1;
    endfunction

endpackage

### design/aik_delay.sv
module aik_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [D];

    // Shift line that moves with the pipeline enable.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < D; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[D-1];

endmodule

### design/aik_sqrt.sv
module aik_sqrt #(
    parameter int IN_W = 42
) (
    input  logic              clk,
    input  logic              en,
    input  logic [IN_W-1:0]   v,
    output logic [IN_W/2-1:0] root
);

    localparam int OUT_W = IN_W / 2;

    logic [IN_W-1:0]  rem_reg [OUT_W];
    logic [OUT_W-1:0] q_reg [OUT_W];

    // One root bit per stage, most significant first.
    for (genvar s = 0; s < OUT_W; s++)
    begin : g_stage
        localparam int K = OUT_W - 1 - s;
        logic [IN_W-1:0]  rem_in;
        logic [IN_W-1:0]  trial;
        logic [IN_W-1:0]  rem_next;
        logic [OUT_W-1:0] q_in;
        logic [OUT_W-1:0] q_next;

        if (s == 0)
        begin : g_first
            assign rem_in = v;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        // (q + 2^K)^2 - q^2; q has no bits at or below K yet.
        assign trial = (IN_W'(q_in) << (K + 1)) | (IN_W'(1) << (2 * K));

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                q_next   = q_in | (OUT_W'(1) << K);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                q_reg[s]   <= q_next;
            end
        end
    end

    assign root = q_reg[OUT_W-1];

endmodule

### design/aik_div.sv
module aik_div
    import aik_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic [DIV_W-1:0] quo
);

    logic [DIV_W-1:0] r_reg [DIV_W];
    logic [DIV_W-1:0] d_reg [DIV_W];
    logic [DIV_W-1:0] q_reg [DIV_W];

    // Restoring division of num * 2^(DIV_W-1) by den, one quotient bit per stage.
    // num never exceeds den, so the first stage works on num unshifted.
    for (genvar s = 0; s < DIV_W; s++)
    begin : g_stage
        logic [DIV_W:0]   rr;
        logic [DIV_W-1:0] d_in;
        logic [DIV_W-1:0] q_in;
        logic [DIV_W-1:0] r_next;
        logic [DIV_W-1:0] q_next;

        if (s == 0)
        begin : g_first
            assign rr   = {1'b0, num};
            assign d_in = den;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign rr   = {r_reg[s-1], 1'b0};
            assign d_in = d_reg[s-1];
            assign q_in = q_reg[s-1];
        end

        always_comb
        begin
            if (rr >= {1'b0, d_in})
            begin
                r_next = DIV_W'(rr - {1'b0, d_in});
                q_next = {q_in[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_next = rr[DIV_W-1:0];
                q_next = {q_in[DIV_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s] <= r_next;
                d_reg[s] <= d_in;
                q_reg[s] <= q_next;
            end
        end
    end

    assign quo = q_reg[DIV_W-1];

endmodule

### design/aik_cordic.sv
module aik_cordic
    import aik_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [CIN_W-1:0] yi,
    input  logic signed [CIN_W-1:0] xi,
    output logic signed [ANG_W-1:0] ang
);

    localparam int K_W = $clog2(NORM_LEN + 1);
    localparam int L_W = $clog2(CIN_W + 1);

    // Normalize stage: left shift that lifts the larger magnitude to at least 2^29.
    logic [CIN_W-1:0] ax;
    logic [CIN_W-1:0] ay;
    logic [CIN_W-1:0] m;
    logic [L_W-1:0]   blen;
    logic [K_W-1:0]   k_next;

    logic signed [CIN_W-1:0] nx_reg;
    logic signed [CIN_W-1:0] ny_reg;
    logic [K_W-1:0]          nk_reg;
    logic                    nz_reg;

    assign ax = xi[CIN_W-1] ? CIN_W'(-xi) : CIN_W'(xi);
    assign ay = yi[CIN_W-1] ? CIN_W'(-yi) : CIN_W'(yi);
    assign m  = (ax > ay) ? ax : ay;

    always_comb
    begin
        blen = '0;
        for (int j = 0; j < CIN_W; j++)
        begin
            if (m[j])
            begin
                blen = L_W'(j + 1);
            end
        end
        if (blen >= L_W'(NORM_LEN))
        begin
            k_next = '0;
        end
        else
        begin
            k_next = K_W'(L_W'(NORM_LEN) - blen);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= xi;
            ny_reg <= yi;
            nk_reg <= k_next;
            nz_reg <= (m == '0);
        end
    end

    // Fold stage: apply the shift and turn the left half plane by 90 degrees.
    logic signed [CX_W-1:0]  sx;
    logic signed [CX_W-1:0]  sy;
    logic signed [CX_W-1:0]  px_next;
    logic signed [CX_W-1:0]  py_next;
    logic signed [ANG_W-1:0] pa_next;

    logic signed [CX_W-1:0]  px_reg;
    logic signed [CX_W-1:0]  py_reg;
    logic signed [ANG_W-1:0] pa_reg;
    logic                    pz_reg;

    assign sx = CX_W'(nx_reg) <<< nk_reg;
    assign sy = CX_W'(ny_reg) <<< nk_reg;

    always_comb
    begin
        px_next = sx;
        py_next = sy;
        pa_next = '0;
        if (sx < 0)
        begin
            if (sy >= 0)
            begin
                px_next = sy;
                py_next = -sx;
                pa_next = ANG_W'(90) <<< ANG_FRAC;
            end
            else
            begin
                px_next = -sy;
                py_next = sx;
                pa_next = -(ANG_W'(90) <<< ANG_FRAC);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pa_reg <= pa_next;
            pz_reg <= nz_reg;
        end
    end

    // Vectoring rotations, one per stage.
    logic signed [CX_W-1:0]  ix_reg [CORDIC_STAGES];
    logic signed [CX_W-1:0]  iy_reg [CORDIC_STAGES];
    logic signed [ANG_W-1:0] ia_reg [CORDIC_STAGES];
    logic                    iz_reg [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        logic signed [CX_W-1:0]  x_in;
        logic signed [CX_W-1:0]  y_in;
        logic signed [ANG_W-1:0] a_in;
        logic                    z_in;
        logic signed [CX_W-1:0]  xs;
        logic signed [CX_W-1:0]  ys;

        if (i == 0)
        begin : g_first
            assign x_in = px_reg;
            assign y_in = py_reg;
            assign a_in = pa_reg;
            assign z_in = pz_reg;
        end
        else
        begin : g_rest
            assign x_in = ix_reg[i-1];
            assign y_in = iy_reg[i-1];
            assign a_in = ia_reg[i-1];
            assign z_in = iz_reg[i-1];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                iz_reg[i] <= z_in;
                if (y_in > 0)
                begin
                    ix_reg[i] <= x_in + ys;
                    iy_reg[i] <= y_in - xs;
                    ia_reg[i] <= a_in + atan_q24(i);
                end
                else
                begin
                    ix_reg[i] <= x_in - ys;
                    iy_reg[i] <= y_in + xs;
                    ia_reg[i] <= a_in - atan_q24(i);
                end
            end
        end
    end

    // A zero vector has angle zero.
    assign ang = iz_reg[CORDIC_STAGES-1] ? '0 : ia_reg[CORDIC_STAGES-1];

endmodule

### design/aik_law.sv
module aik_law
    import aik_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [LEN_W-1:0]        p,
    input  logic [LEN_W-1:0]        q,
    input  logic [LEN_W-1:0]        opp,
    output logic signed [ANG_W-1:0] ang
);

    localparam int SQ_W  = 2 * LEN_W;
    localparam int NW    = SQ_W + 3;
    localparam int DENW  = SQ_W + 1;
    localparam int SH_W  = $clog2(DENW - DIV_W + 1);
    localparam int UU_W  = 2 * DIV_W;
    localparam int CL    = cordic_lat(CORDIC_STAGES);

    // Squares and the side product.
    logic [SQ_W-1:0] pp_reg;
    logic [SQ_W-1:0] qq_reg;
    logic [SQ_W-1:0] oo_reg;
    logic [SQ_W-1:0] pq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg <= SQ_W'(p * p);
            qq_reg <= SQ_W'(q * q);
            oo_reg <= SQ_W'(opp * opp);
            pq_reg <= SQ_W'(p * q);
        end
    end

    // Cosine-rule numerator and denominator.
    logic signed [NW-1:0] n_reg;
    logic [DENW-1:0]      den_reg;
    logic                 zr2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= $signed(NW'(pp_reg)) + $signed(NW'(qq_reg)) - $signed(NW'(oo_reg));
            den_reg <= {pq_reg, 1'b0};
            zr2_reg <= (pq_reg == '0);
        end
    end

    // Right shift that brings the denominator below 2^31.
    logic [SH_W-1:0]      sh_next;
    logic signed [NW-1:0] n3_reg;
    logic [DENW-1:0]      den3_reg;
    logic [SH_W-1:0]      sh3_reg;
    logic                 zr3_reg;

    always_comb
    begin
        sh_next = '0;
        for (int j = DIV_W; j < DENW; j++)
        begin
            if (den_reg[j])
            begin
                sh_next = SH_W'(j - DIV_W + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n3_reg   <= n_reg;
            den3_reg <= den_reg;
            sh3_reg  <= sh_next;
            zr3_reg  <= zr2_reg;
        end
    end

    // Scale, clamp the ratio to [-1, 1] and split off the sign.
    logic signed [NW-1:0] ns;
    logic [DENW-1:0]      ds_full;
    logic signed [NW-1:0] dsx;
    logic signed [NW-1:0] cl;
    logic signed [NW-1:0] cl_abs;

    logic [DIV_W-1:0] absn_reg;
    logic [DIV_W-1:0] dsv_reg;
    logic             neg_reg;
    logic             zr4_reg;

    assign ns      = n3_reg >>> sh3_reg;
    assign ds_full = den3_reg >> sh3_reg;
    assign dsx     = $signed({{(NW-DIV_W){1'b0}}, ds_full[DIV_W-1:0]});

    always_comb
    begin
        if (ns > dsx)
        begin
            cl = dsx;
        end
        else if (ns < -dsx)
        begin
            cl = -dsx;
        end
        else
        begin
            cl = ns;
        end
        cl_abs = cl[NW-1] ? -cl : cl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            absn_reg <= cl_abs[DIV_W-1:0];
            dsv_reg  <= ds_full[DIV_W-1:0];
            neg_reg  <= cl[NW-1];
            zr4_reg  <= zr3_reg;
        end
    end

    // Cosine magnitude in Q30.
    logic [DIV_W-1:0] quo;
    logic             neg_d;

    aik_div u_div (
        .clk (clk),
        .en  (en),
        .num (absn_reg),
        .den (dsv_reg),
        .quo (quo)
    );

    aik_delay #(.W(1), .D(DIV_W)) u_neg_dly (
        .clk  (clk),
        .en   (en),
        .din  (neg_reg),
        .dout (neg_d)
    );

    // Signed cosine, then sine from 1 - cos^2.
    logic signed [CIN_W-1:0] u_reg;
    logic [UU_W-1:0]         uu_reg;
    logic [UU_W-1:0]         v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg  <= neg_d ? -$signed(CIN_W'(quo)) : $signed(CIN_W'(quo));
            uu_reg <= UU_W'(u_reg * u_reg);
            v_reg  <= (UU_W'(1) << (2 * (DIV_W - 1))) - uu_reg;
        end
    end

    logic [DIV_W-1:0]        s_root;
    logic signed [CIN_W-1:0] u_d;

    aik_sqrt #(.IN_W(UU_W)) u_sqrt (
        .clk  (clk),
        .en   (en),
        .v    (v_reg),
        .root (s_root)
    );

    aik_delay #(.W(CIN_W), .D(DIV_W + 2)) u_u_dly (
        .clk  (clk),
        .en   (en),
        .din  (u_reg),
        .dout (u_d)
    );

    // Angle from sine and cosine.
    logic signed [ANG_W-1:0] c_ang;
    logic                    zr_d;

    aik_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .clk (clk),
        .en  (en),
        .yi  ($signed(CIN_W'(s_root))),
        .xi  (u_d),
        .ang (c_ang)
    );

    aik_delay #(.W(1), .D(DIV_W + 3 + DIV_W + CL)) u_zr_dly (
        .clk  (clk),
        .en   (en),
        .din  (zr4_reg),
        .dout (zr_d)
    );

    // A zero-length side gives angle zero.
    logic signed [ANG_W-1:0] ang_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg <= zr_d ? '0 : c_ang;
        end
    end

    assign ang = ang_reg;

endmodule

### design/arm_inverse_kinematics.sv
// Channel   Direction  Word
// s_t*      in         tdata: coord_x[19:0], coord_y[39:20], coord_z[59:40], zeros to 64
// m_t*      out        tdata: shoulder_angle[17:0], elbow_angle[35:18], base_angle[51:36],
//                      zeros to 56; tuser: out_of_reach
// p*        config     APB, byte address 4*i for length registers 0 to 3
//
// One word is accepted every cycle while the skid stage is not full; each result is
// computed by the two square roots, the ratio divider, the sine root and the CORDIC
// rotations, each one bit or step a stage. Reset clears the valid bits of the
// pipeline, the output register and the skid stage, and loads the default lengths.
// A stall downstream fills the skid stage and then freezes the whole pipeline;
// s_tready is the registered inverse of the skid stage being full.
module arm_inverse_kinematics
    import aik_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // coord_x [19:0], coord_y [39:20], coord_z [59:40]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // shoulder_angle [17:0], elbow_angle [35:18], base_angle [51:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    // out_of_reach [0]
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CL    = cordic_lat(CORDIC_STAGES);
    localparam int LAW   = law_lat(CORDIC_STAGES);
    localparam int T_D   = 2 + R_W + 1;
    localparam int T_C   = T_D + 2 + C_W;
    localparam int T_ATN = T_C + LAW - CL;
    localparam int TOT   = T_C + LAW + 2;
    localparam int RSH   = ANG_FRAC - FRAC_BITS;
    localparam int SUM_W = ANG_W + 3;
    localparam int OUT_W = SHOULDER_W + ELBOW_W + BASE_W + 1;

    // Configuration registers.
    logic [CFG_W-1:0] upper_arm_length_reg;
    logic [CFG_W-1:0] forearm_length_reg;
    logic [CFG_W-1:0] head_offset_reg;
    logic [CFG_W-1:0] center_offset_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_arm_length_reg <= cfg_reset(UPPER_ARM_MM, FRAC_BITS);
            forearm_length_reg   <= cfg_reset(FOREARM_MM, FRAC_BITS);
            head_offset_reg      <= cfg_reset(HEAD_OFS_MM, FRAC_BITS);
            center_offset_reg    <= cfg_reset(CENTER_OFS_MM, FRAC_BITS);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_UPPER_ARM:  upper_arm_length_reg <= pwdata[CFG_W-1:0];
                REG_FOREARM:    forearm_length_reg   <= pwdata[CFG_W-1:0];
                REG_HEAD_OFS:   head_offset_reg      <= pwdata[CFG_W-1:0];
                REG_CENTER_OFS: center_offset_reg    <= pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_UPPER_ARM:  prdata = 32'(upper_arm_length_reg);
            REG_FOREARM:    prdata = 32'(forearm_length_reg);
            REG_HEAD_OFS:   prdata = 32'(head_offset_reg);
            REG_CENTER_OFS: prdata = 32'(center_offset_reg);
            default:        prdata = '0;
        endcase
    end

    // Pipeline enable: the whole pipeline moves unless the skid stage is full.
    logic en;
    logic skid_v_reg;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    logic signed [XYZ_W-1:0] cx;
    logic signed [XYZ_W-1:0] cy;
    logic signed [XYZ_W-1:0] cz;

    assign cx = s_tdata[XYZ_W-1:0];
    assign cy = s_tdata[2*XYZ_W-1:XYZ_W];
    assign cz = s_tdata[3*XYZ_W-1:2*XYZ_W];

    // Valid bits, one per stage.
    logic [TOT-1:0] vpipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpipe_reg <= '0;
        end
        else if (en)
        begin
            vpipe_reg <= {vpipe_reg[TOT-2:0], s_tvalid};
        end
    end

    // Horizontal radius: squares, sum, root.
    logic [2*XYZ_W-1:0] xx_reg;
    logic [2*XYZ_W-1:0] yy_reg;
    logic [2*R_W-1:0]   sum1_reg;
    logic [R_W-1:0]     r_root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg   <= (2*XYZ_W)'(cx * cx);
            yy_reg   <= (2*XYZ_W)'(cy * cy);
            sum1_reg <= (2*R_W)'(xx_reg) + (2*R_W)'(yy_reg);
        end
    end

    aik_sqrt #(.IN_W(2 * R_W)) u_sqrt_r (
        .clk  (clk),
        .en   (en),
        .v    (sum1_reg),
        .root (r_root)
    );

    // Pivot distance and reach.
    logic signed [R_W+1:0]   d_reg;
    logic [LEN_W-1:0]        ad;
    logic signed [XYZ_W-1:0] z_d;
    logic [2*C_W-1:0]        dd_reg;
    logic [2*C_W-1:0]        zz_reg;
    logic [2*C_W-1:0]        sum2_reg;
    logic [C_W-1:0]          c_root;

    aik_delay #(.W(XYZ_W), .D(T_D)) u_z_dly (
        .clk  (clk),
        .en   (en),
        .din  (cz),
        .dout (z_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= $signed((R_W+2)'(r_root)) - $signed((R_W+2)'(center_offset_reg))
                        - $signed((R_W+2)'(head_offset_reg));
            dd_reg   <= (2*C_W)'(d_reg * d_reg);
            zz_reg   <= (2*C_W)'(z_d * z_d);
            sum2_reg <= dd_reg + zz_reg;
        end
    end

    assign ad = d_reg[R_W+1] ? LEN_W'(-d_reg) : LEN_W'(d_reg);

    aik_sqrt #(.IN_W(2 * C_W)) u_sqrt_c (
        .clk  (clk),
        .en   (en),
        .v    (sum2_reg),
        .root (c_root)
    );

    // Triangle check on the reach.
    logic [CFG_W:0]   l_sum;
    logic [CFG_W-1:0] l_diff;
    logic             bad_reg;
    logic             bad_d;

    assign l_sum  = (CFG_W+1)'(upper_arm_length_reg) + (CFG_W+1)'(forearm_length_reg);
    assign l_diff = (upper_arm_length_reg > forearm_length_reg)
                    ? upper_arm_length_reg - forearm_length_reg
                    : forearm_length_reg - upper_arm_length_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad_reg <= (upper_arm_length_reg == '0) || (forearm_length_reg == '0)
                       || (c_root == '0) || (C_W'(c_root) > C_W'(l_sum))
                       || (c_root < C_W'(l_diff));
        end
    end

    aik_delay #(.W(1), .D(LAW - 1)) u_bad_dly (
        .clk  (clk),
        .en   (en),
        .din  (bad_reg),
        .dout (bad_d)
    );

    // Cosine-rule angles: at the shoulder and between the two links.
    logic signed [ANG_W-1:0] a_sh;
    logic signed [ANG_W-1:0] a_el;

    aik_law #(.CORDIC_STAGES(CORDIC_STAGES)) u_law_sh (
        .clk (clk),
        .en  (en),
        .p   (LEN_W'(upper_arm_length_reg)),
        .q   (c_root),
        .opp (LEN_W'(forearm_length_reg)),
        .ang (a_sh)
    );

    aik_law #(.CORDIC_STAGES(CORDIC_STAGES)) u_law_el (
        .clk (clk),
        .en  (en),
        .p   (LEN_W'(upper_arm_length_reg)),
        .q   (LEN_W'(forearm_length_reg)),
        .opp (c_root),
        .ang (a_el)
    );

    // Elevation atan2(z, |d|), timed to finish with the cosine-rule units.
    logic signed [XYZ_W-1:0] z_e;
    logic [LEN_W-1:0]        ad_e;
    logic signed [ANG_W-1:0] a_elev;

    aik_delay #(.W(XYZ_W), .D(T_ATN)) u_ze_dly (
        .clk  (clk),
        .en   (en),
        .din  (cz),
        .dout (z_e)
    );

    aik_delay #(.W(LEN_W), .D(T_ATN - T_D)) u_ad_dly (
        .clk  (clk),
        .en   (en),
        .din  (ad),
        .dout (ad_e)
    );

    aik_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_elev (
        .clk (clk),
        .en  (en),
        .yi  (CIN_W'(z_e)),
        .xi  ($signed(CIN_W'(ad_e))),
        .ang (a_elev)
    );

    // Base rotation atan(y/x), folded to the right half plane.
    logic signed [XYZ_W:0] bx;
    logic signed [XYZ_W:0] by;
    logic signed [XYZ_W:0] bx_e;
    logic signed [XYZ_W:0] by_e;
    logic signed [ANG_W-1:0] a_base;

    assign bx = cx[XYZ_W-1] ? -(XYZ_W+1)'(cx) : (XYZ_W+1)'(cx);
    assign by = cx[XYZ_W-1] ? -(XYZ_W+1)'(cy) : (XYZ_W+1)'(cy);

    aik_delay #(.W(2 * (XYZ_W + 1)), .D(T_ATN)) u_b_dly (
        .clk  (clk),
        .en   (en),
        .din  ({by, bx}),
        .dout ({by_e, bx_e})
    );

    aik_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_base (
        .clk (clk),
        .en  (en),
        .yi  (CIN_W'(by_e)),
        .xi  (CIN_W'(bx_e)),
        .ang (a_base)
    );

    // Joint sums in the fine angle scale.
    logic signed [SUM_W-1:0] shoulder_reg;
    logic signed [SUM_W-1:0] elbow_reg;
    logic signed [SUM_W-1:0] base_reg;
    logic                    bad1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shoulder_reg <= SUM_W'(a_elev) + SUM_W'(a_sh);
            elbow_reg    <= (SUM_W'(180) <<< ANG_FRAC) - SUM_W'(a_elev) - SUM_W'(a_sh)
                            - SUM_W'(a_el);
            base_reg     <= SUM_W'(a_base);
            bad1_reg     <= bad_d;
        end
    end

    // Round half up to the output scale, then saturate.
    logic signed [SUM_W-1:0] sh_r;
    logic signed [SUM_W-1:0] el_r;
    logic signed [SUM_W-1:0] bs_r;
    logic signed [SUM_W-1:0] bs_c;
    logic signed [SUM_W-1:0] base_lim;
    logic [SHOULDER_W-1:0]   sh_sat;
    logic [ELBOW_W-1:0]      el_sat;
    logic [BASE_W-1:0]       bs_sat;

    assign sh_r = (shoulder_reg + (SUM_W'(1) <<< (RSH - 1))) >>> RSH;
    assign el_r = (elbow_reg + (SUM_W'(1) <<< (RSH - 1))) >>> RSH;
    assign bs_r = (base_reg + (SUM_W'(1) <<< (RSH - 1))) >>> RSH;
    assign base_lim = SUM_W'(90) <<< FRAC_BITS;

    function automatic logic signed [SUM_W-1:0] sat_to(input logic signed [SUM_W-1:0] v,
                                                        input int w);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        begin
            hi = (SUM_W'(1) <<< (w - 1)) - SUM_W'(1);
            lo = -(SUM_W'(1) <<< (w - 1));
            if (v > hi)
            begin
                return hi;
            end
            else if (v < lo)
            begin
                return lo;
            end
            return v;
        end
    endfunction

    always_comb
    begin
        if (bs_r > base_lim)
        begin
            bs_c = base_lim;
        end
        else if (bs_r < -base_lim)
        begin
            bs_c = -base_lim;
        end
        else
        begin
            bs_c = bs_r;
        end
    end

    assign sh_sat = SHOULDER_W'(sat_to(sh_r, SHOULDER_W));
    assign el_sat = ELBOW_W'(sat_to(el_r, ELBOW_W));
    assign bs_sat = BASE_W'(sat_to(bs_c, BASE_W));

    logic [OUT_W-1:0] res_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= {bad1_reg, bs_sat, el_sat, sh_sat};
        end
    end

    // Output register with a skid stage behind it.
    logic             vlast;
    logic             leave;
    logic             out_v_reg;
    logic             out_v_next;
    logic             skid_v_next;
    logic [OUT_W-1:0] out_reg;
    logic [OUT_W-1:0] skid_reg;

    assign vlast = vpipe_reg[TOT-1];
    assign leave = en && vlast;

    always_comb
    begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        if (out_v_reg && m_tready)
        begin
            if (skid_v_reg)
            begin
                skid_v_next = 1'b0;
            end
            else
            begin
                out_v_next = 1'b0;
            end
        end
        if (leave)
        begin
            if (!out_v_reg || m_tready)
            begin
                out_v_next = 1'b1;
            end
            else
            begin
                skid_v_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    // A full skid stage freezes the pipeline, so its drain and a new word never meet.
    always_ff @(posedge clk)
    begin
        if (out_v_reg && m_tready && skid_v_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (leave)
        begin
            if (!out_v_reg || m_tready)
            begin
                out_reg <= res_reg;
            end
            else
            begin
                skid_reg <= res_reg;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = 56'(out_reg[OUT_W-2:0]);
    assign m_tuser  = out_reg[OUT_W-1];

endmodule
